// ----- design/touch_threshold_hysteresis_detector_core_macros.svh -----
// Assertion macros used by the touch detector core RTL.
`ifndef TOUCH_THRESHOLD_HYSTERESIS_DETECTOR_CORE_MACROS_SVH
`define TOUCH_THRESHOLD_HYSTERESIS_DETECTOR_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising clock edge outside reset.
`define TTHD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("touch detector check failed");
// Next-cycle implication, checked on every rising clock edge outside reset.
`define TTHD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("touch detector check failed");
`else
`define TTHD_ASSERT_NOW(label, ante, cons)
`define TTHD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- design/tthd_pkg.sv -----
// Types, constants and register codes of the touch threshold detector.
package tthd_pkg;

    localparam int SAMPLE_W = 16;
    localparam int TIME_W   = 32;
    localparam int LEVEL_W  = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 16;

    localparam logic [SAMPLE_W-1:0] OFF_THRESHOLD_RST = 16'd1150;
    localparam logic [SAMPLE_W-1:0] ON_THRESHOLD_RST  = 16'd1500;
    localparam logic [SAMPLE_W-1:0] UPPER_LIMIT_RST   = 16'd4500;
    localparam logic [LEVEL_W-1:0]  LOW_LEVEL_RST     = 7'd0;
    localparam logic [LEVEL_W-1:0]  HIGH_LEVEL_RST    = 7'd127;
    localparam logic [TIME_W-1:0]   HOLD_OFF_MS_RST   = 32'd10;

    localparam logic [CFG_IDX_W-1:0] CFG_OFF_THRESHOLD       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ON_THRESHOLD        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_LIMIT         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOVER_AFTER_RELEASE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_LEVEL           = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LEVEL          = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_OFF_MS         = 3'd6;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_TOUCH   = 2'd1,
        EV_RELEASE = 2'd2,
        EV_OUT     = 2'd3
    } event_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] off_threshold;
        logic [SAMPLE_W-1:0] on_threshold;
        logic [SAMPLE_W-1:0] upper_limit;
        logic                hover_after_release;
        logic [LEVEL_W-1:0]  low_level;
        logic [LEVEL_W-1:0]  high_level;
        logic [TIME_W-1:0]   hold_off_ms;
    } cfg_t;

    typedef struct packed {
        logic              holding_off;
        logic              is_touched;
        logic              is_hovered;
        logic [TIME_W-1:0] event_time;
    } state_t;

    typedef struct packed {
        event_t             event_res;
        logic [LEVEL_W-1:0] level;
    } result_t;

endpackage

// ----- design/touch_threshold_hysteresis_detector_core.sv -----
// Top level of the capacitive touch threshold detector with hysteresis and hold-off.
//
// Each input word carries one raw capacitive sample and the current millisecond
// time, and every input word produces exactly one output word with an event code
// and a level. An untouched sensor whose sample reaches upper_limit reports a touch
// at high_level; a touched sensor whose sample drops below on_threshold reports a
// release (at low_level and becoming hovered when hover_after_release is set, at
// level 0 otherwise); a hovered sensor whose sample drops below off_threshold
// reports out of range at level 0. After any event, samples are ignored until the
// time elapsed since the event, taken modulo 2^32, exceeds hold_off_ms. The block
// accepts one word per clock cycle while the output side keeps reading. A word is
// held in the input register, then the decision logic, three 16-bit compares, a
// 32-bit compare and one 32-bit subtract, updates the sensor state and loads the
// output register once that register is empty or being read. The output
// register decouples the two sides: a new word is accepted whenever the input
// register is empty or moves on in the same cycle. Configuration registers are
// written through cfg_we, cfg_index and cfg_data and should only change while no
// word is in flight.
`include "touch_threshold_hysteresis_detector_core_macros.svh"

module touch_threshold_hysteresis_detector_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write port.
    input  logic                                cfg_we,
    input  logic [tthd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tthd_pkg::CFG_DATA_W-1:0]     cfg_data,
    // Sample stream in.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [tthd_pkg::S_TDATA_W-1:0]      s_tdata,   // [15:0] sample, [47:16] now_ms
    // Result stream out.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [tthd_pkg::M_TDATA_W-1:0]      m_tdata    // [1:0] event_res, [8:2] level, rest 0
);
    import tthd_pkg::*;

    cfg_t                cfg_reg;
    state_t              state_reg;
    state_t              state_next;
    result_t             result_next;
    result_t             result_reg;
    logic                in_valid_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [TIME_W-1:0]   now_ms_reg;
    logic                out_valid_reg;
    logic                advance;

    // A word moves from the input register to the output register when the
    // output register is empty or is being read in this same cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Configuration registers; writes beyond the last index are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.off_threshold       <= OFF_THRESHOLD_RST;
            cfg_reg.on_threshold        <= ON_THRESHOLD_RST;
            cfg_reg.upper_limit         <= UPPER_LIMIT_RST;
            cfg_reg.hover_after_release <= 1'b0;
            cfg_reg.low_level           <= LOW_LEVEL_RST;
            cfg_reg.high_level          <= HIGH_LEVEL_RST;
            cfg_reg.hold_off_ms         <= HOLD_OFF_MS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_OFF_THRESHOLD:       cfg_reg.off_threshold <= cfg_data[SAMPLE_W-1:0];
                CFG_ON_THRESHOLD:        cfg_reg.on_threshold  <= cfg_data[SAMPLE_W-1:0];
                CFG_UPPER_LIMIT:         cfg_reg.upper_limit   <= cfg_data[SAMPLE_W-1:0];
                CFG_HOVER_AFTER_RELEASE: cfg_reg.hover_after_release <= cfg_data[0];
                CFG_LOW_LEVEL:           cfg_reg.low_level     <= cfg_data[LEVEL_W-1:0];
                CFG_HIGH_LEVEL:          cfg_reg.high_level    <= cfg_data[LEVEL_W-1:0];
                CFG_HOLD_OFF_MS:         cfg_reg.hold_off_ms   <= cfg_data[TIME_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            sample_reg <= s_tdata[SAMPLE_W-1:0];
            now_ms_reg <= s_tdata[SAMPLE_W+TIME_W-1:SAMPLE_W];
        end
    end

    tthd_decide u_decide
    (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .sample     (sample_reg),
        .now_ms     (now_ms_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // Sensor state changes only when a word actually passes through the logic.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.holding_off <= 1'b0;
            state_reg.is_touched  <= 1'b0;
            state_reg.is_hovered  <= 1'b0;
            state_reg.event_time  <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - LEVEL_W - 2){1'b0}}, result_reg.level,
                       result_reg.event_res};

    // A quiet result always carries level 0.
    `TTHD_ASSERT_NOW(a_none_level_zero,
        out_valid_reg && result_reg.event_res == EV_NONE, result_reg.level == '0)
    // Any reported event starts a hold-off.
    `TTHD_ASSERT_NEXT(a_event_starts_hold,
        advance && result_next.event_res != EV_NONE, state_reg.holding_off)
    // A sensor is never touched and hovered at the same time.
    `TTHD_ASSERT_NOW(a_touch_hover_exclusive,
        state_reg.is_touched, !state_reg.is_hovered)
    // The state stays put while no word passes through.
    `TTHD_ASSERT_NEXT(a_state_holds,
        !advance, state_reg == $past(state_reg))

endmodule

// ----- design/tthd_decide.sv -----
// Per-sample decision logic: hold-off timing, event priority and state update.
module tthd_decide
(
    input  tthd_pkg::cfg_t                    cfg,
    input  tthd_pkg::state_t                  state,
    input  logic [tthd_pkg::SAMPLE_W-1:0]     sample,
    input  logic [tthd_pkg::TIME_W-1:0]       now_ms,
    output tthd_pkg::state_t                  state_next,
    output tthd_pkg::result_t                 result
);
    import tthd_pkg::*;

    logic [TIME_W-1:0] elapsed;

    // Modulo 2^32 difference, so a wrap of the millisecond counter is harmless.
    assign elapsed = now_ms - state.event_time;

    always_comb
    begin
        state_next       = state;
        result.event_res = EV_NONE;
        result.level     = '0;

        if (state.holding_off)
        begin
            // The sample that ends the hold-off is still ignored.
            if (elapsed > cfg.hold_off_ms)
            begin
                state_next.holding_off = 1'b0;
            end
        end
        else if (sample >= cfg.upper_limit && !state.is_touched)
        begin
            result.event_res      = EV_TOUCH;
            result.level          = cfg.high_level;
            state_next.is_hovered = 1'b0;
            state_next.is_touched = 1'b1;
        end
        else if (sample < cfg.on_threshold && state.is_touched)
        begin
            result.event_res      = EV_RELEASE;
            state_next.is_touched = 1'b0;
            if (cfg.hover_after_release)
            begin
                state_next.is_hovered = 1'b1;
                result.level          = cfg.low_level;
            end
        end
        else if (sample < cfg.off_threshold && state.is_hovered)
        begin
            result.event_res      = EV_OUT;
            state_next.is_touched = 1'b0;
            state_next.is_hovered = 1'b0;
        end

        if (result.event_res != EV_NONE)
        begin
            state_next.event_time  = now_ms;
            state_next.holding_off = 1'b1;
        end
    end

endmodule
